// ----- sv/lru_pkg.sv -----
// ---------------------------------------------------------------------------
// lru_pkg
// Shared widths, types and sequencer states for the LRU page replacement block.
// ---------------------------------------------------------------------------
package lru_pkg;

   localparam int MAX_FRAMES     = 8;
   localparam int FRAME_IDX_BITS = $clog2(MAX_FRAMES);
   localparam int PAGE_BITS      = 16;
   localparam int STAMP_BITS     = 32;
   localparam int FAULT_BITS     = 32;
   localparam int CSR_BITS       = 4;

   localparam logic [CSR_BITS-1:0] FRAMES_RESET = CSR_BITS'(MAX_FRAMES);

   typedef logic [FRAME_IDX_BITS-1:0] frame_idx_type;
   typedef logic [PAGE_BITS-1:0]      page_type;
   typedef logic [STAMP_BITS-1:0]     stamp_type;
   typedef logic [FAULT_BITS-1:0]     fault_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HIT_SCAN,
      ST_MIN_SCAN,
      ST_FINISH
   } state_type;

   // one frame as seen at the read port
   typedef struct packed {
      logic      valid;
      page_type  page;
      stamp_type stamp;
   } frame_rd_type;

   // write command for one frame
   typedef struct packed {
      logic          en;
      frame_idx_type idx;
      page_type      page;
      stamp_type     stamp;
   } frame_wr_type;

endpackage

// ----- sv/lru_if.sv -----
// ---------------------------------------------------------------------------
// lru_if
// Valid/ready channels for page references and replacement results.
// ---------------------------------------------------------------------------
interface lru_req_if import lru_pkg::*; ();
   logic     valid;
   logic     ready;
   page_type page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_rsp_if import lru_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          hit;
   frame_idx_type frame_index;
   logic          evicted_valid;
   page_type      evicted_page;
   fault_type     fault_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

// ----- sv/lru_frame_store.sv -----
// ---------------------------------------------------------------------------
// lru_frame_store
// Per-frame page number, valid bit and last-use stamp, one read and one write port.
// ---------------------------------------------------------------------------
module lru_frame_store import lru_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  frame_idx_type rd_idx,
   output frame_rd_type  rd,
   input  frame_wr_type  wr
);

   page_type              page_ff  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   stamp_type             stamp_ff [MAX_FRAMES];

   // page numbers are only looked at behind a set valid bit
   always_ff @(posedge clock) begin
      if (wr.en) begin
         page_ff[wr.idx] <= wr.page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
         stamp_ff[wr.idx] <= wr.stamp;
      end
   end

   always_comb begin
      rd.valid = valid_ff[rd_idx];
      rd.page  = page_ff[rd_idx];
      rd.stamp = stamp_ff[rd_idx];
   end

endmodule

// ----- sv/lru_page_replacement.sv -----
// ---------------------------------------------------------------------------
// lru_page_replacement
// Timestamp LRU page replacement over up to eight frames.
// ---------------------------------------------------------------------------
// One request beat carries a page number; one response beat comes back for it,
// giving hit or fault, the frame now holding the page, any evicted page and the
// saturating fault total. The frames are walked one per cycle through a single
// read port, with an equality compare and a less-than compare: first a search for
// the page (stops at the first match), then on a miss a search for the smallest
// stamp. Each item is accepted in ST_IDLE, searched in ST_HIT_SCAN and, on a
// miss, ST_MIN_SCAN, and written back in ST_FINISH once the response register is
// free. The request side is ready only while the sequencer is idle; the response
// sits in an output register, so a new request beat may be taken while the
// previous response still waits. csr_wr_data sets the number of managed frames
// (0 acts as 1, above eight acts as eight) and is to be written only while the
// block is idle. Reset clears all frames at once.
// ---------------------------------------------------------------------------
module lru_page_replacement import lru_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lru_req_if.sink             req_chan,
   lru_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CSR_BITS-1:0] csr_wr_data
);

   // sequencer and item registers
   state_type     state_ff, state_in;
   frame_idx_type idx_ff;
   page_type      page_ff;
   stamp_type     acc_ff;
   fault_type     fault_ff;
   logic          found_ff;
   frame_idx_type slot_ff;
   stamp_type     min_stamp_ff;
   logic          min_valid_ff;
   page_type      min_page_ff;
   logic [CSR_BITS-1:0] frames_ff;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   frame_idx_type rsp_frame_ff;
   logic          rsp_ev_valid_ff;
   page_type      rsp_ev_page_ff;
   fault_type     rsp_fault_ff;

   frame_rd_type  frame_rd;
   frame_wr_type  frame_wr;
   frame_idx_type last_idx;
   logic          is_last;
   logic          hit_match;
   logic          take_min;
   logic          req_beat;
   logic          finish_go;
   fault_type     fault_next;

   // ---------------------------------------------------------------------
   // Frame storage
   // ---------------------------------------------------------------------
   lru_frame_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (idx_ff),
      .rd     (frame_rd),
      .wr     (frame_wr)
   );

   // highest managed frame, with the register clamped into range
   always_comb begin
      if (frames_ff == '0) begin
         last_idx = '0;
      end else if (frames_ff > CSR_BITS'(MAX_FRAMES)) begin
         last_idx = FRAME_IDX_BITS'(MAX_FRAMES - 1);
      end else begin
         last_idx = FRAME_IDX_BITS'(frames_ff - 1'b1);
      end
   end

   // the compares: equality in the page search, less-than in the stamp search
   assign is_last   = (idx_ff == last_idx);
   assign hit_match = frame_rd.valid && (frame_rd.page == page_ff);
   assign take_min  = (idx_ff == '0) || (frame_rd.stamp < min_stamp_ff);

   assign fault_next = (!found_ff && (fault_ff != '1)) ? fault_ff + 1'b1 : fault_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_HIT_SCAN;
            end
         end
         ST_HIT_SCAN: begin
            if (hit_match) begin
               state_in = ST_FINISH;
            end else if (is_last) begin
               state_in = ST_MIN_SCAN;
            end
         end
         ST_MIN_SCAN: begin
            if (is_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_chan.ready = 1'b0;
      finish_go      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_FINISH: begin
            // hold the write-back until the response register is free
            finish_go = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   assign req_beat = req_chan.valid && req_chan.ready;

   // write back the chosen frame: a hit only refreshes the stamp, but page and
   // valid are rewritten with the same values
   always_comb begin
      frame_wr.en    = finish_go;
      frame_wr.idx   = slot_ff;
      frame_wr.page  = page_ff;
      frame_wr.stamp = acc_ff;
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         fault_ff     <= '0;
         frames_ff    <= FRAMES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
         // advance the access counter on each request beat, saturating
         if (req_beat && (acc_ff != '1)) begin
            acc_ff <= acc_ff + 1'b1;
         end
         if (finish_go) begin
            fault_ff     <= fault_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Item and search registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               page_ff  <= req_chan.page_number;
               idx_ff   <= '0;
               found_ff <= 1'b0;
            end
         end
         ST_HIT_SCAN: begin
            if (hit_match) begin
               found_ff <= 1'b1;
               slot_ff  <= idx_ff;
            end else if (is_last) begin
               idx_ff <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_MIN_SCAN: begin
            // strict less-than keeps the lowest index on a tie
            if (take_min) begin
               slot_ff      <= idx_ff;
               min_stamp_ff <= frame_rd.stamp;
               min_valid_ff <= frame_rd.valid;
               min_page_ff  <= frame_rd.page;
            end
            if (!is_last) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   // response payload
   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_hit_ff      <= found_ff;
         rsp_frame_ff    <= slot_ff;
         rsp_ev_valid_ff <= !found_ff && min_valid_ff;
         rsp_ev_page_ff  <= (!found_ff && min_valid_ff) ? min_page_ff : '0;
         rsp_fault_ff    <= fault_next;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_index   = rsp_frame_ff;
   assign rsp_chan.evicted_valid = rsp_ev_valid_ff;
   assign rsp_chan.evicted_page  = rsp_ev_page_ff;
   assign rsp_chan.fault_total   = rsp_fault_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT_SCAN || state_ff == ST_MIN_SCAN) |-> (idx_ff <= last_idx))
      else $error("frame scan beyond managed range");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.hit |-> !rsp_chan.evicted_valid)
      else $error("eviction reported on a hit");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fault_ff >= $past(fault_ff)))
      else $error("fault counter went backwards");

   a_stamp_nonzero: assert property (@(posedge clock) disable iff (reset)
      finish_go |-> (frame_wr.stamp != '0))
      else $error("frame written with an empty stamp");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      finish_go |-> (slot_ff <= last_idx))
      else $error("write-back outside managed frames");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamp LRU page replacement block.
// ---------------------------------------------------------------------------
// Page references are queued by a stimulus process and handed to a driver that
// offers them on the request channel with random gaps. Every request beat the
// block takes is run through a local LRU predictor with its own frame table,
// access counter, fault counter and frame-count register. The expected response
// is queued, and each response beat is checked field by field against the
// oldest entry. The run opens with a short directed sequence: page extremes,
// empty frames filling in order, a shrunk range, a regrown range holding a
// duplicate page, a frame count of zero and one above the frame total. Random
// phases follow, each under its own frame count, mostly drawing from a small
// page pool so that hits and evictions are frequent. The receiver stalls at
// random and, in some phases, holds off long enough to back the block up.
// ---------------------------------------------------------------------------
module testbench import lru_pkg::*; ();

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_GAP        = 18;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int IDLE_PAUSE     = 4;
   localparam int RANDOM_PHASES  = 10;
   localparam int REFS_PER_PHASE = 138;

   // directed groups, one per frame-count setting
   localparam page_type FILL_REFS [10] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1111,
      16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666, 16'h7777};
   localparam page_type SHRINK_REFS [3] = '{16'h0000, 16'h8888, 16'h5555};
   localparam page_type SINGLE_REFS [3] = '{16'hAAAA, 16'hAAAA, 16'h5A5A};
   localparam page_type WIDE_REFS [2]   = '{16'h1111, 16'hFFFF};
   localparam page_type DUPLICATE_REF   = 16'h5555;

   localparam logic [CSR_BITS-1:0] PHASE_FRAMES [RANDOM_PHASES] = '{4'd1, 4'd8, 4'd0,
      4'd15, 4'd3, 4'd6, 4'd2, 4'd9, 4'd5, 4'd4};

   typedef struct packed {
      logic          hit;
      frame_idx_type frame_index;
      logic          evicted_valid;
      page_type      evicted_page;
      fault_type     fault_total;
   } replacement_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;

   lru_req_if req_chan ();
   lru_rsp_if rsp_chan ();

   lru_page_replacement DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: a private copy of the frame table and counters
   page_type            pred_page  [MAX_FRAMES];
   logic                pred_valid [MAX_FRAMES];
   stamp_type           pred_stamp [MAX_FRAMES];
   stamp_type           pred_accesses;
   fault_type           pred_faults;
   logic [CSR_BITS-1:0] pred_frames;

   page_type        refs_pending [$];
   replacement_type replacements_due [$];

   int  refs_queued    = 0;
   int  refs_accepted  = 0;
   int  hits_seen      = 0;
   int  faults_seen    = 0;
   int  evictions_seen = 0;
   int  settings_used  = 0;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;
   int  send_gap       = 0;
   int  take_gap       = 0;
   int  hold_left      = 0;
   bit  send_calm      = 1'b0;
   bit  take_calm      = 1'b0;
   bit  long_hold_due  = 1'b0;

   // Clock: high half then low half
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Work out the response for one page reference and advance the frame table.
   function automatic replacement_type predict_replacement(page_type page);
      replacement_type outcome;
      int              managed;
      int              slot;
      bit              resident;
      stamp_type       now;
      managed  = (pred_frames == 0) ? 1 :
                 (pred_frames > MAX_FRAMES) ? MAX_FRAMES : int'(pred_frames);
      resident = 1'b0;
      slot     = 0;
      outcome  = '0;
      if (pred_accesses != '1)
         pred_accesses++;
      now = pred_accesses;
      // lowest-index match wins, even if a regrown range holds a duplicate
      for (int f = 0; f < managed; f++) begin
         if (!resident && pred_valid[f] && pred_page[f] == page) begin
            resident = 1'b1;
            slot     = f;
         end
      end
      if (resident) begin
         pred_stamp[slot] = now;
      end else begin
         if (pred_faults != '1)
            pred_faults++;
         // smallest stamp wins, ties to the lowest index; empty frames hold 0
         slot = 0;
         for (int f = 1; f < managed; f++) begin
            if (pred_stamp[f] < pred_stamp[slot])
               slot = f;
         end
         if (pred_valid[slot]) begin
            outcome.evicted_valid = 1'b1;
            outcome.evicted_page  = pred_page[slot];
         end
         pred_page[slot]  = page;
         pred_valid[slot] = 1'b1;
         pred_stamp[slot] = now;
      end
      outcome.hit         = resident;
      outcome.frame_index = frame_idx_type'(slot);
      outcome.fault_total = pred_faults;
      return outcome;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Request driver: hold a beat until taken, then idle for a drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap != 0 || refs_pending.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (send_gap != 0)
               send_gap--;
         end else begin
            req_chan.valid       <= 1'b1;
            req_chan.page_number <= refs_pending.pop_front();
            send_gap = draw_gap(send_calm);
         end
      end
   end

   // Response receiver: random stalls per beat, plus an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap  = 0;
         hold_left = 0;
      end else begin
         if (long_hold_due) begin
            hold_left     = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            take_gap = draw_gap(take_calm);
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: check response beats, predict request beats, track the register
   always @(posedge clock) begin
      replacement_type want;
      if (reset) begin
         for (int f = 0; f < MAX_FRAMES; f++) begin
            pred_page[f]  = '0;
            pred_valid[f] = 1'b0;
            pred_stamp[f] = '0;
         end
         pred_accesses = '0;
         pred_faults   = '0;
         pred_frames   = FRAMES_RESET;
         replacements_due.delete();
         quiet_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (replacements_due.size() == 0) begin
               $display("%0t ns: response beat with nothing expected, expected none, actual %0h",
                        $time, {rsp_chan.hit, rsp_chan.frame_index, rsp_chan.evicted_valid,
                                rsp_chan.evicted_page, rsp_chan.fault_total});
               fail_count++;
            end else begin
               want = replacements_due.pop_front();
               check_field("hit", want.hit, rsp_chan.hit);
               check_field("frame_index", want.frame_index, rsp_chan.frame_index);
               check_field("evicted_valid", want.evicted_valid, rsp_chan.evicted_valid);
               check_field("evicted_page", want.evicted_page, rsp_chan.evicted_page);
               check_field("fault_total", want.fault_total, rsp_chan.fault_total);
               hits_seen      += want.hit;
               faults_seen    += !want.hit;
               evictions_seen += want.evicted_valid;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            replacements_due.push_back(predict_replacement(req_chan.page_number));
            refs_accepted++;
         end
         if (csr_wr_en)
            pred_frames = csr_wr_data;
         // watchdog: count cycles in which no beat and no write goes through
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, replacements_due.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_ref(page_type page);
      refs_pending.push_back(page);
      refs_queued++;
   endtask

   // Wait for every queued reference to be answered
   task automatic wait_drained();
      do
         @(posedge clock);
      while (refs_accepted != refs_queued || replacements_due.size() != 0);
   endtask

   // Write the frame count once the block has gone idle
   task automatic set_frames(logic [CSR_BITS-1:0] value);
      wait_drained();
      repeat (IDLE_PAUSE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // One random phase: a small page pool for locality, with stray pages mixed in
   task automatic run_random_phase(logic [CSR_BITS-1:0] frames, bit hold_long);
      page_type pool [$];
      int       pool_len;
      int       sweep;
      set_frames(frames);
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      if (hold_long)
         long_hold_due = 1'b1;
      pool_len = $urandom_range(1, 12);
      sweep    = 0;
      repeat (pool_len) pool.push_back(page_type'($urandom));
      repeat (REFS_PER_PHASE) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               queue_ref(page_type'($urandom));
            end
            2: begin
               // walk the pool in order, the classic worst case for LRU
               queue_ref(pool[sweep]);
               sweep = (sweep + 1) % pool_len;
            end
            default: begin
               queue_ref(pool[$urandom_range(0, pool_len - 1)]);
            end
         endcase
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.page_number = '0;
      rsp_chan.ready       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Fill empty frames in order at the reset frame count, then evict the oldest
      foreach (FILL_REFS[i]) queue_ref(FILL_REFS[i]);
      // Shrink to two frames: a page resident beyond the range must fault
      set_frames(4'd2);
      foreach (SHRINK_REFS[i]) queue_ref(SHRINK_REFS[i]);
      // Regrow: the same page now sits in two frames, lowest index must hit
      set_frames(4'd8);
      queue_ref(DUPLICATE_REF);
      // Zero acts as one frame
      set_frames(4'd0);
      foreach (SINGLE_REFS[i]) queue_ref(SINGLE_REFS[i]);
      // Above the frame total acts as all eight
      set_frames(4'd15);
      foreach (WIDE_REFS[i]) queue_ref(WIDE_REFS[i]);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         run_random_phase((p % 4 == 3) ? 4'($urandom_range(0, 15)) : PHASE_FRAMES[p],
                          (p == 2 || p == 7));
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (replacements_due.size() != 0) begin
         $display("%0t ns: responses missing, expected %0d more, actual 0",
                  $time, replacements_due.size());
         fail_count++;
      end

      $display("Covered %0d page references over %0d frame-count settings",
               refs_accepted, settings_used);
      $display("  %0d hits, %0d faults, %0d evictions, %0d mismatches",
               hits_seen, faults_seen, evictions_seen, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- lru_page_replacement.f -----
sv/lru_pkg.sv
sv/lru_if.sv
sv/lru_frame_store.sv
sv/lru_page_replacement.sv
test/testbench.sv
